// File: design/lcas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcas_pkg
// Shared types and constants for the life step unit (B3/S23 rule).
// ----------------------------------------------------------------------------
package lcas_pkg;

    localparam int ROW_IDX_W  = 5;
    localparam int CELLS_W    = 32;
    localparam int MAX_EMIT   = 32;

    // B3/S23 neighbor counts
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] KEEP_LOW    = 4'd2;
    localparam logic [3:0] KEEP_HIGH   = 4'd3;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_STEP = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic                 req_type;
        logic [ROW_IDX_W-1:0] row_index;
        logic [CELLS_W-1:0]   row_cells;
    } req_item_t;

    typedef struct packed {
        logic [ROW_IDX_W-1:0] out_row;
        logic [CELLS_W-1:0]   out_cells;
        logic                 unchanged;
        logic                 last_row;
    } res_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH0,
        ST_FETCH1,
        ST_COMPUTE,
        ST_LAST
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_wr;    // write request row into the board
        logic start;      // clear change flag for a new generation
        logic rd_en;      // issue a board read
        logic prime;      // load first window row
        logic commit;     // write back new row, slide window
        logic push_row;   // send new row as a result
        logic save_last;  // hold final emitted row until the pass ends
        logic push_last;  // send the held final row
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;   // output register can take a transaction
        logic row_ok;     // load row index lies on the board
    } dp_status_t;

endpackage

// File: design/lcas_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcas_req_if
// Request channel: valid/ready handshake carrying one load or step item.
// ----------------------------------------------------------------------------
interface lcas_req_if;
    import lcas_pkg::*;

    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/lcas_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcas_res_if
// Result channel: valid/ready handshake carrying one emitted board row.
// ----------------------------------------------------------------------------
interface lcas_res_if;
    import lcas_pkg::*;

    logic      valid;
    logic      ready;
    res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/life_cellular_automaton_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_cellular_automaton_step_unit
// Game of Life (B3/S23) on a GRID_WIDTH x GRID_HEIGHT board, no wraparound.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | transaction
//  ---------+-----+------------------------------------------+-----------------
//  request  | in  | req_type, row_index, row_cells           | load row / step
//  result   | out | out_row, out_cells, unchanged, last_row  | one new row
//
//  Load: written straight into the board when the request is taken, no result.
//  Step: after the request transaction, ST_FETCH0 and ST_FETCH1 fill the row
//  window, then ST_COMPUTE moves one row per cycle through the update logic
//  (set by the single board write port) while the result side does not stall,
//  and ST_LAST sends the final row. A new step is taken only back in idle,
//  after the final row of the previous step has been sent.
//  Up to 32 rows are emitted; the last one carries last_row and unchanged and
//  is sent only after every row has been rewritten and compared.
//  A stalled result holds the row walk; the request side is taken only idle.
//  Reset clears per-row valid bits at once, so the board reads all dead with
//  no clearing pass.
// ----------------------------------------------------------------------------
module life_cellular_automaton_step_unit
    import lcas_pkg::*;
#(
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_HEIGHT = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    lcas_req_if.sink   request,
    lcas_res_if.source result
);

    localparam int RW = $clog2(GRID_HEIGHT);

    ctrl_cmd_t     cmd;
    dp_status_t    status;
    logic [RW-1:0] row;
    logic [RW-1:0] rd_addr;

    // sequencer: owns the request handshake and the row counter
    lcas_ctrl #(
        .GRID_HEIGHT (GRID_HEIGHT),
        .RW          (RW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_type  (request.data.req_type),
        .req_ready (request.ready),
        .status    (status),
        .cmd       (cmd),
        .row       (row),
        .rd_addr   (rd_addr)
    );

    // datapath: board memory, window, update logic, output register
    lcas_dp #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .RW          (RW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (request.data),
        .cmd       (cmd),
        .row       (row),
        .rd_addr   (rd_addr),
        .status    (status),
        .res_ready (result.ready),
        .res_valid (result.valid),
        .res_data  (result.data)
    );

endmodule

// File: design/lcas_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcas_ctrl
// Sequencer: accepts requests, walks the rows of a generation, paces output.
// ----------------------------------------------------------------------------
module lcas_ctrl
    import lcas_pkg::*;
#(
    parameter int GRID_HEIGHT = 32,
    parameter int RW          = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_type,
    output logic          req_ready,
    input  dp_status_t    status,
    output ctrl_cmd_t     cmd,
    output logic [RW-1:0] row,
    output logic [RW-1:0] rd_addr
);

    localparam int EMIT = (GRID_HEIGHT < MAX_EMIT) ? GRID_HEIGHT : MAX_EMIT;

    state_t        state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        rd_addr    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_type == REQ_STEP)
                    begin
                        cmd.start  = 1'b1;
                        row_next   = '0;
                        state_next = ST_FETCH0;
                    end
                    else
                    begin
                        cmd.load_wr = status.row_ok;
                    end
                end
            end
            ST_FETCH0:
            begin
                cmd.rd_en  = 1'b1;
                rd_addr    = '0;
                state_next = ST_FETCH1;
            end
            ST_FETCH1:
            begin
                cmd.rd_en  = 1'b1;
                cmd.prime  = 1'b1;
                rd_addr    = RW'(1);
                state_next = ST_COMPUTE;
            end
            ST_COMPUTE:
            begin
                // rows before the final emitted one need room at the output
                if ((int'(row_reg) >= EMIT - 1) || status.out_free)
                begin
                    cmd.commit    = 1'b1;
                    cmd.push_row  = (int'(row_reg) < EMIT - 1);
                    cmd.save_last = (int'(row_reg) == EMIT - 1);
                    cmd.rd_en     = (int'(row_reg) + 2 < GRID_HEIGHT);
                    rd_addr       = RW'(int'(row_reg) + 2);
                    if (int'(row_reg) == GRID_HEIGHT - 1)
                    begin
                        row_next   = '0;
                        state_next = ST_LAST;
                    end
                    else
                    begin
                        row_next = row_reg + RW'(1);
                    end
                end
            end
            ST_LAST:
            begin
                if (status.out_free)
                begin
                    cmd.push_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign row = row_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_row || cmd.push_last) |-> status.out_free)
        else $error("result pushed into an occupied output register");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (row_reg == '0))
        else $error("row counter not cleared between generations");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAST) |->
            ($past(state_reg) == ST_COMPUTE || $past(state_reg) == ST_LAST))
        else $error("final row sent without a full pass");

endmodule

// File: design/lcas_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcas_dp
// Board memory, three-row window, B3/S23 row update and output register.
// ----------------------------------------------------------------------------
module lcas_dp
    import lcas_pkg::*;
#(
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_HEIGHT = 32,
    parameter int RW          = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  req_item_t     req_data,
    input  ctrl_cmd_t     cmd,
    input  logic [RW-1:0] row,
    input  logic [RW-1:0] rd_addr,
    output dp_status_t    status,
    input  logic          res_ready,
    output logic          res_valid,
    output res_item_t     res_data
);

    localparam int EMIT = (GRID_HEIGHT < MAX_EMIT) ? GRID_HEIGHT : MAX_EMIT;
    localparam int VIS  = (GRID_WIDTH < CELLS_W) ? GRID_WIDTH : CELLS_W;

    // board storage; valid bits stand in for the reset clear
    logic [GRID_WIDTH-1:0]  mem [GRID_HEIGHT];
    logic [GRID_HEIGHT-1:0] valid_reg;
    logic [GRID_WIDTH-1:0]  rd_raw_reg;
    logic                   rd_valid_reg;

    logic [GRID_WIDTH-1:0]  above_reg;
    logic [GRID_WIDTH-1:0]  cur_reg;
    logic [GRID_WIDTH-1:0]  below;
    logic [GRID_WIDTH-1:0]  rd_row;
    logic [GRID_WIDTH-1:0]  new_row;
    logic [GRID_WIDTH-1:0]  load_row;
    logic [CELLS_W-1:0]     new_vis;
    logic [CELLS_W-1:0]     last_cells_reg;
    logic                   any_change_reg;

    logic                   wr_en;
    logic [RW-1:0]          wr_addr;
    logic [GRID_WIDTH-1:0]  wr_data;

    logic                   out_valid_reg;
    res_item_t              out_item_reg;

    assign rd_row = rd_valid_reg ? rd_raw_reg : '0;
    // row below the last one is outside the board
    assign below  = (int'(row) == GRID_HEIGHT - 1) ? '0 : rd_row;

    always_comb
    begin
        load_row = '0;
        for (int c = 0; c < VIS; c++)
        begin
            load_row[c] = req_data.row_cells[c];
        end
    end

    // B3/S23 update of one full row, columns in parallel
    always_comb
    begin
        logic [3:0] cnt;
        int         cc;
        new_row = '0;
        for (int c = 0; c < GRID_WIDTH; c++)
        begin
            cnt = '0;
            for (int d = -1; d <= 1; d++)
            begin
                cc = c + d;
                if (cc >= 0 && cc < GRID_WIDTH)
                begin
                    cnt = cnt + 4'(above_reg[cc]) + 4'(below[cc]);
                    if (d != 0)
                    begin
                        cnt = cnt + 4'(cur_reg[cc]);
                    end
                end
            end
            if (cur_reg[c])
            begin
                new_row[c] = (cnt == KEEP_LOW) || (cnt == KEEP_HIGH);
            end
            else
            begin
                new_row[c] = (cnt == BIRTH_COUNT);
            end
        end
    end

    always_comb
    begin
        new_vis = '0;
        for (int c = 0; c < VIS; c++)
        begin
            new_vis[c] = new_row[c];
        end
    end

    assign wr_en   = cmd.load_wr || cmd.commit;
    assign wr_addr = cmd.commit ? row : RW'(req_data.row_index);
    assign wr_data = cmd.commit ? new_row : load_row;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // sliding window: above holds the old contents of the previous row
    always_ff @(posedge clk)
    begin
        if (cmd.prime)
        begin
            above_reg <= '0;
            cur_reg   <= rd_row;
        end
        else if (cmd.commit)
        begin
            above_reg <= cur_reg;
            cur_reg   <= below;
        end
        if (cmd.save_last)
        begin
            last_cells_reg <= new_vis;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_change_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            any_change_reg <= 1'b0;
        end
        else if (cmd.commit && (new_row != cur_reg))
        begin
            any_change_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push_row || cmd.push_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_row)
        begin
            out_item_reg.out_row   <= ROW_IDX_W'(row);
            out_item_reg.out_cells <= new_vis;
            out_item_reg.unchanged <= 1'b0;
            out_item_reg.last_row  <= 1'b0;
        end
        else if (cmd.push_last)
        begin
            out_item_reg.out_row   <= ROW_IDX_W'(EMIT - 1);
            out_item_reg.out_cells <= last_cells_reg;
            out_item_reg.unchanged <= !any_change_reg;
            out_item_reg.last_row  <= 1'b1;
        end
    end

    assign status.out_free = !out_valid_reg || res_ready;
    assign status.row_ok   = (int'(req_data.row_index) < GRID_HEIGHT);
    assign res_valid       = out_valid_reg;
    assign res_data        = out_item_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.unchanged) |-> out_item_reg.last_row)
        else $error("unchanged flag on a row other than the last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.last_row) |->
            (int'(out_item_reg.out_row) == EMIT - 1))
        else $error("last row flag on the wrong row index");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !cmd.load_wr && (int'(row) < GRID_HEIGHT))
        else $error("row write back outside the board");

endmodule
